@@ rtl/edc_pkg.sv @@
// Shared types and constants for the expert dispatch counting-sort engine.
// No dependencies; imported by every module of the block.
package edc_pkg;

	localparam int MAX_EXPERTS = 16;
	localparam int MAX_TOKENS  = 65536;
	localparam int EXP_W       = $clog2(MAX_EXPERTS);
	localparam int CNT_W       = $clog2(MAX_TOKENS + 1);
	localparam int OP_W        = 2;
	localparam int NE_W        = 5;
	localparam int SLOT_W      = 16;
	localparam int ORD_W       = 16;
	localparam int STAT_W      = 2;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [NE_W-1:0] NE_RESET = NE_W'(8);

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_COUNT = 2'd1;
	localparam logic [OP_W-1:0] OP_PLACE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_EXPERT = 2'd1;
	localparam logic [STAT_W-1:0] ST_CAPACITY   = 2'd2;
	localparam logic [STAT_W-1:0] ST_LATE_COUNT = 2'd3;

	typedef enum logic [2:0] {
		K_CLEAR,
		K_COUNT,
		K_PLACE,
		K_BAD,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [EXP_W-1:0] expert;
	} job_t;

endpackage

@@ rtl/edc_front.sv @@
// Front end: input acceptance, expert count register and job classification.
// Depends on edc_pkg.
module edc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [edc_pkg::OP_W-1:0]  operation,
	input  logic [edc_pkg::EXP_W-1:0] expert_id,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [edc_pkg::NE_W-1:0]  cfg_data,
	output logic                    push_valid,
	input  logic                    push_ready,
	output edc_pkg::job_t           push_job
);
	import edc_pkg::*;

	logic [NE_W-1:0] num_experts_q;
	logic            bad_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_experts_q <= NE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_experts_q <= cfg_data;
		end
	end

	assign cfg_ready  = 1'b1;
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// ids are narrower than MAX_EXPERTS, so only the register limit matters
	assign bad_id = NE_W'(expert_id) >= num_experts_q;

	always_comb begin
		push_job.expert = expert_id;
		unique case (operation)
			OP_CLEAR: push_job.kind = K_CLEAR;
			OP_COUNT: push_job.kind = bad_id ? K_BAD : K_COUNT;
			OP_PLACE: push_job.kind = bad_id ? K_BAD : K_PLACE;
			OP_NONE:  push_job.kind = K_NOP;
			default:  push_job.kind = K_NOP;
		endcase
	end

endmodule

@@ rtl/edc_queue.sv @@
// Short job queue between the front end and the execution back end.
// Depends on edc_pkg.
module edc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  edc_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output edc_pkg::job_t pop_job
);
	import edc_pkg::*;

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] fill_q;
	logic               push_fire;
	logic               pop_fire;

	assign push_ready = fill_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		ptr_next = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop_fire) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push_fire && !pop_fire) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ rtl/edc_back.sv @@
// Back end: per-expert counter file, prefix-sum sweep and result register.
// Depends on edc_pkg.
module edc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  edc_pkg::job_t             pop_job,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [edc_pkg::SLOT_W-1:0] slot,
	output logic [edc_pkg::ORD_W-1:0]  token_ordinal,
	output logic [edc_pkg::CNT_W-1:0]  expert_start,
	output logic [edc_pkg::CNT_W-1:0]  expert_count,
	output logic [edc_pkg::STAT_W-1:0] status
);
	import edc_pkg::*;

	typedef enum logic {
		S_RUN,
		S_SWEEP
	} state_t;

	localparam logic [EXP_W-1:0] LAST_IDX = EXP_W'(MAX_EXPERTS - 1);

	state_t             state_q;
	logic [CNT_W-1:0]   counts_q [MAX_EXPERTS];
	logic [CNT_W-1:0]   used_q   [MAX_EXPERTS];
	logic [CNT_W-1:0]   starts_q [MAX_EXPERTS];
	logic               placing_q;
	logic               starts_ok_q;
	logic [CNT_W-1:0]   counted_q;
	logic [ORD_W-1:0]   placed_q;
	logic [EXP_W-1:0]   sw_idx_q;
	logic [CNT_W-1:0]   acc_q;

	logic               out_valid_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [ORD_W-1:0]   ordinal_q;
	logic [CNT_W-1:0]   start_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAT_W-1:0]  status_q;

	logic [EXP_W-1:0]   e;
	logic [CNT_W-1:0]   cnt_rd;
	logic [CNT_W-1:0]   used_rd;
	logic [CNT_W-1:0]   start_rd;
	logic [CNT_W-1:0]   cnt_inc;
	logic               need_sweep;
	logic               fire;
	logic               do_count;
	logic               do_place;
	logic [SLOT_W-1:0]  r_slot;
	logic [ORD_W-1:0]   r_ord;
	logic [CNT_W-1:0]   r_start;
	logic [CNT_W-1:0]   r_count;
	logic [STAT_W-1:0]  r_status;

	assign e        = pop_job.expert;
	assign cnt_rd   = counts_q[e];
	assign used_rd  = used_q[e];
	assign start_rd = starts_q[e];
	assign cnt_inc  = cnt_rd + 1'b1;

	// start table is stale while counting goes on: rebuild before a place
	assign need_sweep = pop_valid && (pop_job.kind == K_PLACE) && !placing_q && !starts_ok_q;
	assign pop_ready  = (state_q == S_RUN) && (!out_valid_q || out_ready) && !need_sweep;
	assign fire       = pop_valid && pop_ready;

	always_comb begin
		r_slot   = '0;
		r_ord    = '0;
		r_start  = '0;
		r_count  = '0;
		r_status = ST_OK;
		do_count = 1'b0;
		do_place = 1'b0;
		unique case (pop_job.kind)
			K_CLEAR: ;
			K_NOP:   ;
			K_BAD:   r_status = ST_BAD_EXPERT;
			K_COUNT: begin
				r_count = cnt_rd;
				if (placing_q) begin
					r_status = ST_LATE_COUNT;
				end else if (counted_q == CNT_W'(MAX_TOKENS)) begin
					r_status = ST_CAPACITY;
				end else begin
					do_count = 1'b1;
					r_count  = cnt_inc;
				end
			end
			K_PLACE: begin
				r_start = start_rd;
				r_count = cnt_rd;
				if (used_rd >= cnt_rd) begin
					r_status = ST_CAPACITY;
				end else begin
					do_place = 1'b1;
					r_slot   = SLOT_W'(start_rd + used_rd);
					r_ord    = placed_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			placing_q   <= 1'b0;
			starts_ok_q <= 1'b0;
			counted_q   <= '0;
			placed_q    <= '0;
			sw_idx_q    <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_EXPERTS; i++) begin
				counts_q[i] <= '0;
				used_q[i]   <= '0;
			end
		end else begin
			unique case (state_q)
				S_RUN: begin
					if (need_sweep) begin
						state_q  <= S_SWEEP;
						sw_idx_q <= '0;
						acc_q    <= '0;
					end
				end
				S_SWEEP: begin
					acc_q <= acc_q + counts_q[sw_idx_q];
					if (sw_idx_q == LAST_IDX) begin
						state_q     <= S_RUN;
						starts_ok_q <= 1'b1;
					end else begin
						sw_idx_q <= sw_idx_q + 1'b1;
					end
				end
				default: state_q <= S_RUN;
			endcase

			if (fire) begin
				out_valid_q <= 1'b1;
				if (pop_job.kind == K_CLEAR) begin
					placing_q   <= 1'b0;
					starts_ok_q <= 1'b0;
					counted_q   <= '0;
					placed_q    <= '0;
					for (int i = 0; i < MAX_EXPERTS; i++) begin
						counts_q[i] <= '0;
						used_q[i]   <= '0;
					end
				end
				if (do_count) begin
					counts_q[e] <= cnt_inc;
					counted_q   <= counted_q + 1'b1;
					starts_ok_q <= 1'b0;
				end
				if (do_place) begin
					used_q[e] <= used_rd + 1'b1;
					placed_q  <= placed_q + 1'b1;
					placing_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SWEEP) begin
			starts_q[sw_idx_q] <= acc_q;
		end
		if (fire) begin
			slot_q    <= r_slot;
			ordinal_q <= r_ord;
			start_q   <= r_start;
			count_q   <= r_count;
			status_q  <= r_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign slot          = slot_q;
	assign token_ordinal = ordinal_q;
	assign expert_start  = start_q;
	assign expert_count  = count_q;
	assign status        = status_q;

	a_placing_has_starts: assert property (@(posedge clk) disable iff (!arst_n)
		placing_q |-> starts_ok_q)
		else $error("placing without a valid start table");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && sw_idx_q == LAST_IDX) |=> (state_q == S_RUN && starts_ok_q))
		else $error("prefix sweep did not complete");

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (slot_q == '0 && ordinal_q == '0))
		else $error("slot or ordinal given on a failed item");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pop_job.kind == K_CLEAR) |=> (!placing_q && counted_q == '0 && placed_q == '0))
		else $error("clear left batch state behind");

endmodule

@@ rtl/expert_dispatch_counting_sort_top.sv @@
// Top level of the expert dispatch counting-sort engine.
// Depends on edc_pkg, edc_front, edc_queue and edc_back.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_ready    | operation, expert_id
//  out     | out_valid / out_ready  | slot, token_ordinal, expert_start,
//          |                        | expert_count, status
//  cfg     | cfg_valid / cfg_ready  | cfg_data (num_experts)
//
// One word per cycle through front, two-entry queue and back end, while results are taken and no sweep runs.
// A place word seen while the batch is still counting and the start table is
// stale holds the back end: it is spotted first, then the back end sweeps the
// counter file one expert per cycle to build the prefix sums.
// Counters clear at reset in flops; no clearing pass. cfg is always ready.
// The back end holds while a result waits; the queue keeps taking words until full.
module expert_dispatch_counting_sort_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [edc_pkg::OP_W-1:0]   operation,
	input  logic [edc_pkg::EXP_W-1:0]  expert_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [edc_pkg::SLOT_W-1:0] slot,
	output logic [edc_pkg::ORD_W-1:0]  token_ordinal,
	output logic [edc_pkg::CNT_W-1:0]  expert_start,
	output logic [edc_pkg::CNT_W-1:0]  expert_count,
	output logic [edc_pkg::STAT_W-1:0] status,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [edc_pkg::NE_W-1:0]   cfg_data
);
	import edc_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	edc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.expert_id  (expert_id),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	edc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	edc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_job       (pop_job),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.slot          (slot),
		.token_ordinal (token_ordinal),
		.expert_start  (expert_start),
		.expert_count  (expert_count),
		.status        (status)
	);

endmodule

@@ tb/expert_dispatch_counting_sort_top_test.sv @@
// Self-checking testbench for expert_dispatch_counting_sort_top: directed table, random
// count/place batches over several num_experts settings, and a closing stretch with no idling.
// Depends on edc_pkg and the RTL of the block.
module expert_dispatch_counting_sort_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import edc_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [ORD_W-1:0]  ordinal;
		logic [CNT_W-1:0]  start;
		logic [CNT_W-1:0]  count;
		logic [STAT_W-1:0] status;
	} dispatch_word_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [EXP_W-1:0] eid;
		logic             typed;
		dispatch_word_t   want;
	} stim_row_t;

	localparam dispatch_word_t NO_WORD = '0;
	localparam dispatch_word_t BAD_WORD = '{16'd0, 16'd0, 17'd0, 17'd0, ST_BAD_EXPERT};
	localparam int N_DIRECTED = 24;

	// after reset num_experts is 8 and every counter is zero
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{OP_COUNT, 4'd15, 1'b1, BAD_WORD},
		'{OP_PLACE, 4'd8,  1'b1, BAD_WORD},
		'{OP_NONE,  4'd5,  1'b1, NO_WORD},
		'{OP_CLEAR, 4'd15, 1'b1, NO_WORD},
		'{OP_COUNT, 4'd0,  1'b1, '{16'd0, 16'd0, 17'd0, 17'd1, ST_OK}},
		'{OP_COUNT, 4'd7,  1'b1, '{16'd0, 16'd0, 17'd0, 17'd1, ST_OK}},
		'{OP_COUNT, 4'd7,  1'b1, '{16'd0, 16'd0, 17'd0, 17'd2, ST_OK}},
		'{OP_COUNT, 4'd3,  1'b0, NO_WORD},
		// empty expert: refused, block stays in counting
		'{OP_PLACE, 4'd5,  1'b1, '{16'd0, 16'd0, 17'd2, 17'd0, ST_CAPACITY}},
		'{OP_COUNT, 4'd0,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd0,  1'b0, NO_WORD},
		'{OP_COUNT, 4'd0,  1'b1, '{16'd0, 16'd0, 17'd0, 17'd2, ST_LATE_COUNT}},
		'{OP_PLACE, 4'd7,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd7,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd7,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd3,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd0,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd0,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd9,  1'b1, BAD_WORD},
		'{OP_CLEAR, 4'd0,  1'b1, NO_WORD},
		'{OP_PLACE, 4'd2,  1'b1, '{16'd0, 16'd0, 17'd0, 17'd0, ST_CAPACITY}},
		'{OP_COUNT, 4'd7,  1'b0, NO_WORD},
		'{OP_PLACE, 4'd7,  1'b0, NO_WORD},
		'{OP_NONE,  4'd15, 1'b1, NO_WORD}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   operation = OP_CLEAR;
	logic [EXP_W-1:0]  expert_id = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [SLOT_W-1:0] slot;
	logic [ORD_W-1:0]  token_ordinal;
	logic [CNT_W-1:0]  expert_start;
	logic [CNT_W-1:0]  expert_count;
	logic [STAT_W-1:0] status;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [NE_W-1:0]   cfg_data = '0;

	// predictor state
	logic [CNT_W-1:0] dispatch_counts  [MAX_EXPERTS];
	logic [CNT_W-1:0] dispatch_starts  [MAX_EXPERTS];
	logic [CNT_W-1:0] dispatch_cursors [MAX_EXPERTS];
	logic             placing;
	logic [CNT_W-1:0] counted_total;
	logic [CNT_W-1:0] placed_total;
	logic [NE_W-1:0]  active_experts;

	dispatch_word_t expected_words[$];
	int             mismatches = 0;
	int             words_sent = 0;
	bit             idle_on = 1'b0;
	bit             hold_off_req = 1'b0;

	expert_dispatch_counting_sort_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.expert_id    (expert_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.token_ordinal(token_ordinal),
		.expert_start (expert_start),
		.expert_count (expert_count),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("expert_dispatch_counting_sort_top_test: errors");
		$finish;
	end

	function automatic void clear_tables();
		int i;
		for (i = 0; i < MAX_EXPERTS; i++) begin
			dispatch_counts[i] = '0;
			dispatch_starts[i] = '0;
			dispatch_cursors[i] = '0;
		end
		placing = 1'b0;
		counted_total = '0;
		placed_total = '0;
	endfunction

	// one word in, one word out; updates the batch tables as the block should
	function automatic dispatch_word_t route_token(input logic [OP_W-1:0] op,
			input logic [EXP_W-1:0] eid);
		dispatch_word_t r;
		int acc, s, cur, i;
		r = '0;
		case (op)
			OP_CLEAR: begin
				clear_tables();
			end
			OP_COUNT, OP_PLACE: begin
				// ids are 4 bits, so only the register can make one bad
				if (eid >= active_experts) begin
					r.status = ST_BAD_EXPERT;
				end else if (op == OP_COUNT) begin
					r.count = dispatch_counts[eid];
					if (placing) begin
						r.status = ST_LATE_COUNT;
					end else if (counted_total >= MAX_TOKENS) begin
						r.status = ST_CAPACITY;
					end else begin
						dispatch_counts[eid] += 1'b1;
						counted_total += 1'b1;
						r.count = dispatch_counts[eid];
					end
				end else begin
					if (placing) begin
						s = int'(dispatch_starts[eid]);
						cur = int'(dispatch_cursors[eid]);
					end else begin
						acc = 0;
						for (i = 0; i < int'(eid); i++)
							acc += int'(dispatch_counts[i]);
						s = acc;
						cur = acc;
					end
					r.start = CNT_W'(s);
					r.count = dispatch_counts[eid];
					if (cur >= s + int'(dispatch_counts[eid])) begin
						r.status = ST_CAPACITY;
					end else begin
						if (!placing) begin
							acc = 0;
							for (i = 0; i < MAX_EXPERTS; i++) begin
								dispatch_starts[i] = CNT_W'(acc);
								dispatch_cursors[i] = CNT_W'(acc);
								acc += int'(dispatch_counts[i]);
							end
							placing = 1'b1;
						end
						r.slot = dispatch_cursors[eid][SLOT_W-1:0];
						dispatch_cursors[eid] += 1'b1;
						r.ordinal = placed_total[ORD_W-1:0];
						placed_total += 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_word(input logic [OP_W-1:0] op, input logic [EXP_W-1:0] eid,
			input bit typed = 1'b0, input dispatch_word_t want = '0);
		dispatch_word_t predicted;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		expert_id <= eid;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = route_token(op, eid);
		expected_words.push_back(typed ? want : predicted);
		if (op != OP_NONE)
			words_sent++;
	endtask

	// drop valid and let every pending word come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_experts(input logic [NE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		active_experts = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// clear (most times), count a token list, then place all or the first part of it again in order, with some noise
	task automatic run_batch(input int ne);
		logic [EXP_W-1:0] tokens[$];
		logic [EXP_W-1:0] id;
		int n, lim, k, stop, pick;
		lim = (ne > MAX_EXPERTS) ? MAX_EXPERTS : ne;
		if ($urandom_range(0, 9) != 0)
			send_word(OP_CLEAR, EXP_W'($urandom));
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
		for (k = 0; k < n; k++) begin
			if (lim == 0 || $urandom_range(0, 19) == 0)
				id = EXP_W'($urandom_range(0, 15));
			else
				id = EXP_W'($urandom_range(0, lim - 1));
			tokens.push_back(id);
			send_word(OP_COUNT, id);
			if ($urandom_range(0, 29) == 0)
				send_word(OP_NONE, EXP_W'($urandom));
		end
		stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n;
		for (k = 0; k < stop; k++) begin
			pick = $urandom_range(0, 29);
			if (pick == 0)
				send_word(OP_COUNT, EXP_W'($urandom));
			else if (pick == 1)
				send_word(OP_PLACE, EXP_W'($urandom));
			send_word(OP_PLACE, tokens[k]);
		end
		if ($urandom_range(0, 3) == 0)
			send_word(OP_PLACE, EXP_W'($urandom));
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (64) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (burst == 0 && idle_on && $urandom_range(0, 5) == 0)
					burst = $urandom_range(1, 4);
				if (burst > 0) begin
					out_ready <= 1'b0;
					burst--;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		dispatch_word_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{slot, token_ordinal, expert_start, expert_count, status};
			// let the sender log a word accepted on this same edge first
			#1;
			if (expected_words.size() == 0) begin
				flag_mismatch("unrequested word, status", got.status, 0);
			end else begin
				want = expected_words.pop_front();
				if (got.slot != want.slot)
					flag_mismatch("slot", got.slot, want.slot);
				if (got.ordinal != want.ordinal)
					flag_mismatch("token_ordinal", got.ordinal, want.ordinal);
				if (got.start != want.start)
					flag_mismatch("expert_start", got.start, want.start);
				if (got.count != want.count)
					flag_mismatch("expert_count", got.count, want.count);
				if (got.status != want.status)
					flag_mismatch("status", got.status, want.status);
			end
		end
	end

	initial begin
		int ne_plan[8] = '{16, 0, 1, 31, 17, 4, 12, 8};
		int p, ne, phase_start, i;
		dispatch_word_t w;

		clear_tables();
		active_experts = NE_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_on = 1'b1;
		for (i = 0; i < N_DIRECTED; i++)
			send_word(directed_rows[i].op, directed_rows[i].eid,
				directed_rows[i].typed, directed_rows[i].want);

		words_sent = 0;
		p = 0;
		while (words_sent < 840) begin
			ne = (p < 8) ? ne_plan[p] : $urandom_range(0, 31);
			drain_results();
			write_experts(NE_W'(ne));
			phase_start = words_sent;
			while (words_sent - phase_start < 110 && words_sent < 840) begin
				idle_on = ($urandom_range(0, 2) != 0);
				if (p == 5 && words_sent == phase_start)
					hold_off_req = 1'b1;
				run_batch(ne);
			end
			p++;
		end

		// closing stretch, no idling from here on
		idle_on = 1'b0;
		drain_results();
		write_experts(NE_RESET);
		send_word(OP_CLEAR, 4'd3);
		repeat (4) send_word(OP_COUNT, 4'd0);
		// expert 1 starts right past expert 0's region and is empty
		w = '{16'd0, 16'd0, 17'd4, 17'd0, ST_CAPACITY};
		send_word(OP_PLACE, 4'd1, 1'b1, w);
		w = '{16'd0, 16'd0, 17'd0, 17'd4, ST_OK};
		send_word(OP_PLACE, 4'd0, 1'b1, w);
		repeat (3) send_word(OP_PLACE, 4'd0);
		w = '{16'd0, 16'd0, 17'd0, 17'd4, ST_LATE_COUNT};
		send_word(OP_COUNT, 4'd0, 1'b1, w);
		send_word(OP_PLACE, 4'd15, 1'b1, BAD_WORD);
		while (words_sent < 900)
			run_batch(int'(NE_RESET));
		drain_results();

		if (mismatches == 0)
			$display("expert_dispatch_counting_sort_top_test: clean");
		else
			$display("expert_dispatch_counting_sort_top_test: errors");
		$finish;
	end

endmodule

@@ expert_dispatch_counting_sort_top.f @@
rtl/edc_pkg.sv
rtl/edc_front.sv
rtl/edc_queue.sv
rtl/edc_back.sv
rtl/expert_dispatch_counting_sort_top.sv
tb/expert_dispatch_counting_sort_top_test.sv
